### rtl/core/hkd_pkg.sv
// ----------------------------------------------------------------------------
// hkd_pkg
// Shared types, constants and word functions for the header keystream
// decryptor: generator constants, key schedule constants and helpers.
// ----------------------------------------------------------------------------
package hkd_pkg;

    localparam int unsigned MT_WORDS = 624;
    localparam int unsigned MT_SHIFT = 397;
    localparam int unsigned IDX_W    = $clog2(MT_WORDS);
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 31;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam word_t SEED_MULT    = 32'd1812433253;
    localparam word_t MATRIX_A     = 32'h9908_b0df;
    localparam word_t TEMPER_B     = 32'h9d2c_5680;
    localparam word_t TEMPER_C     = 32'hefc6_0000;
    localparam word_t DEFAULT_SEED = 32'd5489;
    localparam word_t SEED_OFFSET  = 32'd6;

    localparam byte_t KEY_INIT    = 8'hC5;
    localparam byte_t STEP_INIT   = 8'h83;
    localparam byte_t STEP_GROWTH = 8'h53;

    localparam idx_t LAST_IDX  = idx_t'(MT_WORDS - 1);
    localparam idx_t SHIFT_IDX = idx_t'(MT_SHIFT);
    localparam idx_t ONE_IDX   = idx_t'(1);

    // Add an offset below MT_WORDS and wrap around the state ring
    function automatic idx_t wrap_add(idx_t base, idx_t offs);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (IDX_W+1)'(MT_WORDS))
        begin
            sum = sum - (IDX_W+1)'(MT_WORDS);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Regenerate one state word from the word, its successor and the far word
    function automatic word_t twist(word_t cur, word_t nxt, word_t far);
        word_t y;
        word_t v;
        y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
        v = far ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ MATRIX_A;
        end
        return v;
    endfunction

    function automatic word_t temper(word_t y);
        word_t t;
        t = y ^ (y >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    // One step of the seeding recurrence
    function automatic word_t seed_step(word_t prev, idx_t i);
        word_t mix;
        mix = prev ^ (prev >> 30);
        return word_t'(mix * SEED_MULT) + word_t'(i);
    endfunction

endpackage

### rtl/core/hkd_cipher_if.sv
// ----------------------------------------------------------------------------
// hkd_cipher_if
// Input channel: one encrypted header byte and its start flag per word.
// ----------------------------------------------------------------------------
interface hkd_cipher_if;

    logic          valid;
    logic          ready;
    hkd_pkg::byte_t cipher_byte;
    logic          start_of_header;

    modport source
    (
        output valid,
        output cipher_byte,
        output start_of_header,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  cipher_byte,
        input  start_of_header,
        output ready
    );

endinterface

### rtl/core/hkd_plain_if.sv
// ----------------------------------------------------------------------------
// hkd_plain_if
// Output channel: one decrypted header byte per word.
// ----------------------------------------------------------------------------
interface hkd_plain_if;

    logic          valid;
    logic          ready;
    hkd_pkg::byte_t plain_byte;

    modport source
    (
        output valid,
        output plain_byte,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  plain_byte,
        output ready
    );

endinterface

### rtl/core/header_keystream_decryptor_unit.sv
// Flow: one byte at a time, taken only in ST_IDLE. A non-reseeding byte reads
//   two state words on accept; a reseeding byte (start flag, or first byte
//   ever) seeds in ST_SEED and reads in ST_READ. ST_CALC twists, writes back
//   one word and registers the output byte, holding while the output is full.
// Reset: control state cleared; the 624-word state memory is not cleared,
//   the first byte seeds it in a sweep over all 624 words.
// ----------------------------------------------------------------------------
// header_keystream_decryptor_unit
// Decrypts header bytes with the low byte of a lazily twisted MT19937 word
// XOR a running key byte. The generator state lives in one memory.
// ----------------------------------------------------------------------------
module header_keystream_decryptor_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    hkd_cipher_if.sink                  cipher,
    hkd_plain_if.source                 plain,
    input  logic                        cfg_we,
    input  logic [hkd_pkg::LEN_W-1:0]   cfg_wdata
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_CALC
    } state_t;

    state_t                      state_reg;
    hkd_pkg::idx_t               idx_reg;
    hkd_pkg::idx_t               seed_idx_reg;
    logic                        seeded_reg;
    hkd_pkg::byte_t              key_reg;
    hkd_pkg::byte_t              step_reg;
    logic [hkd_pkg::LEN_W-1:0]   len_reg;
    logic                        out_valid_reg;
    hkd_pkg::byte_t              out_byte_reg;

    hkd_pkg::word_t              cur_reg;
    hkd_pkg::word_t              prev_reg;
    hkd_pkg::byte_t              byte_reg;
    hkd_pkg::word_t              rd_a_reg;
    hkd_pkg::word_t              rd_b_reg;

    hkd_pkg::word_t              state_mem [hkd_pkg::MT_WORDS];

    logic                        accept;
    logic                        reseed;
    logic                        rd_en;
    logic                        calc_go;
    logic                        mem_we;
    hkd_pkg::idx_t               rd_a_addr;
    hkd_pkg::idx_t               rd_b_addr;
    hkd_pkg::idx_t               wr_addr;
    hkd_pkg::idx_t               idx_next;
    hkd_pkg::word_t              wr_data;
    hkd_pkg::word_t              seed_value;
    hkd_pkg::word_t              seed_word;
    hkd_pkg::word_t              new_word;
    hkd_pkg::word_t              tempered;
    hkd_pkg::byte_t              key_eff;
    hkd_pkg::byte_t              step_eff;
    hkd_pkg::byte_t              key_next;
    hkd_pkg::byte_t              step_next;

    assign cipher.ready     = (state_reg == ST_IDLE);
    assign plain.valid      = out_valid_reg;
    assign plain.plain_byte = out_byte_reg;

    assign accept = cipher.valid && cipher.ready;
    assign reseed = cipher.start_of_header || !seeded_reg;

    assign key_eff   = cipher.start_of_header ? hkd_pkg::KEY_INIT  : key_reg;
    assign step_eff  = cipher.start_of_header ? hkd_pkg::STEP_INIT : step_reg;
    assign key_next  = key_eff + step_eff;
    assign step_next = step_eff + hkd_pkg::STEP_GROWTH;

    assign seed_value = cipher.start_of_header
                        ? ({1'b0, len_reg} + hkd_pkg::SEED_OFFSET)
                        : hkd_pkg::DEFAULT_SEED;

    // Word 0 of the sweep is the seed itself
    assign seed_word = (seed_idx_reg == '0) ? prev_reg
                       : hkd_pkg::seed_step(prev_reg, seed_idx_reg);

    assign rd_en     = (accept && !reseed) || (state_reg == ST_READ);
    assign rd_a_addr = hkd_pkg::wrap_add(idx_reg, hkd_pkg::ONE_IDX);
    assign rd_b_addr = hkd_pkg::wrap_add(idx_reg, hkd_pkg::SHIFT_IDX);
    assign idx_next  = rd_a_addr;

    assign calc_go  = (state_reg == ST_CALC) && (!out_valid_reg || plain.ready);
    assign new_word = hkd_pkg::twist(cur_reg, rd_a_reg, rd_b_reg);
    assign tempered = hkd_pkg::temper(new_word);

    assign mem_we  = (state_reg == ST_SEED) || calc_go;
    assign wr_addr = (state_reg == ST_SEED) ? seed_idx_reg : idx_reg;
    assign wr_data = (state_reg == ST_SEED) ? seed_word : new_word;

    // State memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            state_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= state_mem[rd_a_addr];
            rd_b_reg <= state_mem[rd_b_addr];
        end
    end

    // Payload path
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= cipher.cipher_byte ^ key_eff;
            if (reseed)
            begin
                prev_reg <= seed_value;
                cur_reg  <= seed_value;
            end
        end
        if (state_reg == ST_SEED)
        begin
            prev_reg <= seed_word;
        end
        if (calc_go)
        begin
            // Successor word is still the old value of the next entry
            cur_reg      <= rd_a_reg;
            out_byte_reg <= byte_reg ^ tempered[hkd_pkg::BYTE_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            seed_idx_reg  <= '0;
            seeded_reg    <= 1'b0;
            key_reg       <= hkd_pkg::KEY_INIT;
            step_reg      <= hkd_pkg::STEP_INIT;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end

            if (calc_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (plain.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg  <= key_next;
                        step_reg <= step_next;
                        if (reseed)
                        begin
                            state_reg    <= ST_SEED;
                            seed_idx_reg <= '0;
                            seeded_reg   <= 1'b1;
                            idx_reg      <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_CALC;
                        end
                    end
                end
                ST_SEED:
                begin
                    if (seed_idx_reg == hkd_pkg::LAST_IDX)
                    begin
                        seed_idx_reg <= '0;
                        state_reg    <= ST_READ;
                    end
                    else
                    begin
                        seed_idx_reg <= seed_idx_reg + hkd_pkg::ONE_IDX;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    // Hold until the output register frees up
                    if (calc_go)
                    begin
                        idx_reg   <= idx_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg <= hkd_pkg::LAST_IDX) && (seed_idx_reg <= hkd_pkg::LAST_IDX))
        else $error("state index out of ring");

    a_reseed_enters_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && reseed) |=> (state_reg == ST_SEED) && seeded_reg)
        else $error("reseeding word did not start the seed sweep");

    a_seed_ends_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SEED) && (seed_idx_reg == hkd_pkg::LAST_IDX))
        |=> (state_reg == ST_READ))
        else $error("seed sweep did not finish into read");

    a_calc_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        calc_go |=> plain.valid && (state_reg == ST_IDLE))
        else $error("computed word not presented on output");
`endif

endmodule
